/* hdl/kpsn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan package
// Shared types, constants and the key character table for the 4x4 keypad
// scanner with decimal number entry.
// ----------------------------------------------------------------------------
package kpsn_pkg;

    // Widths of the request and result fields
    localparam int COL_W   = 4;
    localparam int ROW_W   = 4;
    localparam int CODE_W  = 8;
    localparam int NUM_W   = 32;
    localparam int DEB_W   = 16;

    // Column and row levels with nothing pulled low
    localparam logic [COL_W-1:0] ALL_HIGH = 4'hF;
    localparam logic [DEB_W-1:0] DEB_MAX  = 16'hFFFF;
    localparam logic [DEB_W-1:0] DEB_RESET = 16'd20;

    // Character codes that bound the digit keys
    localparam logic [CODE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE = 8'h39;

    // Scan phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_ROWSCAN  = 5'b00100,
        PH_COLFIND  = 5'b01000,
        PH_RELEASE  = 5'b10000
    } t_phase;

    // One result of a scan tick
    typedef struct packed {
        logic              number_done;
        logic [NUM_W-1:0]  number_value;
        logic [CODE_W-1:0] key_code;
        logic              key_valid;
        logic [ROW_W-1:0]  row_drive;
    } t_result;

    // Row pattern with one row pulled low
    function automatic logic [ROW_W-1:0] single_row_low(input logic [1:0] row);
        logic [ROW_W-1:0] pat;
        pat      = ALL_HIGH;
        pat[row] = 1'b0;
        return pat;
    endfunction

    // Key characters, rows 0..3 by columns 0..3
    function automatic logic [CODE_W-1:0] key_char(input logic [3:0] idx);
        logic [CODE_W-1:0] ch;
        unique case (idx)
            4'd0:    ch = "7";
            4'd1:    ch = "8";
            4'd2:    ch = "9";
            4'd3:    ch = "/";
            4'd4:    ch = "4";
            4'd5:    ch = "5";
            4'd6:    ch = "6";
            4'd7:    ch = "X";
            4'd8:    ch = "1";
            4'd9:    ch = "2";
            4'd10:   ch = "3";
            4'd11:   ch = "-";
            4'd12:   ch = "C";
            4'd13:   ch = "0";
            4'd14:   ch = "=";
            default: ch = "+";
        endcase
        return ch;
    endfunction

endpackage

/* hdl/kpsn_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan state machine
// Holds the scan state and the number accumulator, and forms the result of
// one tick from the column levels of the current request.
// ----------------------------------------------------------------------------
module kpsn_scan
    import kpsn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [DEB_W-1:0]  i_cfg_wr_data,
    input  logic              i_step,
    input  logic [COL_W-1:0]  i_col_levels,
    output t_result           o_result
);

    t_phase            r_phase,     n_phase;
    logic [DEB_W-1:0]  r_deb_count, n_deb_count;
    logic [DEB_W-1:0]  r_deb_ticks;
    logic [2:0]        r_scan_row,  n_scan_row;
    logic [1:0]        r_found_row, n_found_row;
    logic [1:0]        r_found_col, n_found_col;
    logic [NUM_W-1:0]  r_accum,     n_accum;

    logic [DEB_W-1:0]  deb_inc;
    logic [2:0]        row_inc;
    logic [ROW_W-1:0]  drive;
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              is_digit;
    logic [NUM_W-1:0]  accum_x10;
    logic [NUM_W-1:0]  shown;
    logic              done;

    // Saturating debounce count and next row index
    assign deb_inc = (r_deb_count == DEB_MAX) ? r_deb_count : r_deb_count + 1'b1;
    assign row_inc = r_scan_row + 3'd1;

    // Advance the scan one step
    always_comb begin
        n_phase     = r_phase;
        n_deb_count = r_deb_count;
        n_scan_row  = r_scan_row;
        n_found_row = r_found_row;
        n_found_col = r_found_col;
        drive       = '0;
        valid       = 1'b0;
        code        = '0;
        unique case (r_phase)
            PH_DEBOUNCE: begin
                n_deb_count = deb_inc;
                if (deb_inc >= r_deb_ticks) begin
                    n_scan_row = 3'd0;
                    drive      = single_row_low(2'd0);
                    n_phase    = PH_ROWSCAN;
                end
            end
            PH_ROWSCAN: begin
                if (i_col_levels != ALL_HIGH) begin
                    n_found_row = r_scan_row[1:0];
                    n_phase     = PH_COLFIND;
                end else begin
                    n_scan_row = row_inc;
                    if (row_inc[2]) begin
                        n_phase = PH_IDLE;
                    end else begin
                        drive = single_row_low(row_inc[1:0]);
                    end
                end
            end
            PH_COLFIND: begin
                n_phase = PH_RELEASE;
                priority if (!i_col_levels[0]) begin
                    n_found_col = 2'd0;
                end else if (!i_col_levels[1]) begin
                    n_found_col = 2'd1;
                end else if (!i_col_levels[2]) begin
                    n_found_col = 2'd2;
                end else if (!i_col_levels[3]) begin
                    n_found_col = 2'd3;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RELEASE: begin
                if (i_col_levels == ALL_HIGH) begin
                    valid   = 1'b1;
                    code    = key_char({r_found_row, r_found_col});
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_col_levels != ALL_HIGH) begin
                    n_deb_count = '0;
                    n_phase     = PH_DEBOUNCE;
                end
            end
        endcase
    end

    // Build the number: times ten as shift-and-add
    assign is_digit  = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
    assign accum_x10 = {r_accum[NUM_W-4:0], 3'b000} + {r_accum[NUM_W-2:0], 1'b0};

    always_comb begin
        n_accum = r_accum;
        shown   = r_accum;
        done    = 1'b0;
        if (valid) begin
            if (is_digit) begin
                n_accum = accum_x10 + {{(NUM_W-CODE_W){1'b0}}, code - CHAR_ZERO};
                shown   = n_accum;
            end else begin
                done    = 1'b1;
                n_accum = '0;
            end
        end
    end

    assign o_result = '{
        number_done:  done,
        number_value: shown,
        key_code:     code,
        key_valid:    valid,
        row_drive:    drive
    };

    // Hold the debounce length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= DEB_RESET;
        end else if (i_cfg_wr_en) begin
            r_deb_ticks <= i_cfg_wr_data;
        end
    end

    // Update the scan state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_deb_count <= '0;
            r_scan_row  <= '0;
            r_found_row <= '0;
            r_found_col <= '0;
            r_accum     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_deb_count <= n_deb_count;
            r_scan_row  <= n_scan_row;
            r_found_row <= n_found_row;
            r_found_col <= n_found_col;
            r_accum     <= n_accum;
        end
    end

endmodule

/* hdl/keypad_scan_number_entry.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner with decimal number entry
// 4x4 matrix keypad scanner; digit keys build a decimal number.
// ----------------------------------------------------------------------------
// Each request carries one sample of the column pins and yields exactly one
// result: the row pattern to drive next, the key reported on release (if
// any), and the running number. A request is taken every cycle while the
// skid register is empty; its result is registered in the output register,
// or in the skid register when the output is stalled. This two-entry buffer
// lets the input side take one more request while the downstream stalls.
// The debounce length is written through i_cfg_wr_en / i_cfg_wr_data and
// must only be changed while no results are outstanding.
// ----------------------------------------------------------------------------
module keypad_scan_number_entry
    import kpsn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [DEB_W-1:0]  i_cfg_wr_data,   // debounce_ticks
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,    // [3:0] col_levels, [7:4] zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,    // [3:0] row_drive, [11:4] key_code,
                                               // [43:12] number_value, [47:44] zero
    output logic              m_axis_tuser,    // key_valid
    output logic              m_axis_tlast     // number_done
);

    logic    in_take;
    logic    out_take;
    t_result scan_res;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    assign s_axis_tready = !r_skid_valid;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    kpsn_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (in_take),
        .i_col_levels  (s_axis_tdata[COL_W-1:0]),
        .o_result      (scan_res)
    );

    // Output stage control: fill, drain and spill into the skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_take && r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            if (!r_out_valid || out_take) begin
                r_out_valid <= r_skid_valid || in_take;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : scan_res;
        end
        if (!r_skid_valid && in_take) begin
            r_skid <= scan_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.number_value, r_out.key_code, r_out.row_drive};
    assign m_axis_tuser  = r_out.key_valid;
    assign m_axis_tlast  = r_out.number_done;

endmodule

/* test/keypad_scan_number_entry_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner with number entry: testbench
// Feeds column samples shaped as key presses (debounce, row scan, column
// find and release), plus failed scans and noise, through the request
// stream. A built-in scan predictor works out each result, and every result
// taken from the output stream is checked field by field against the oldest
// prediction. The debounce length is swept between phases, and both stream
// sides idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module keypad_scan_number_entry_test;
    import kpsn_pkg::*;

    localparam int STALL_LIMIT = 1000;   // cycles with no transfer on either side
    localparam int LONG_HOLD   = 60;
    localparam int HOLD_AFTER  = 300;    // results seen before the long hold-off

    // Key characters, index {row, col}; index 0 sits in the lowest byte
    localparam logic [127:0] KEY_CHARS = "+=0C-321X654/987";

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [DEB_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [3:0] col_levels, [7:4] zero
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;         // [3:0] row_drive, [11:4] key_code,
                                             // [43:12] number_value, [47:44] zero
    logic              m_axis_tuser;         // key_valid
    logic              m_axis_tlast;         // number_done

    // Scan predictor state and its copy of the debounce register
    t_phase            scan_phase     = PH_IDLE;
    logic [DEB_W-1:0]  deb_count      = '0;
    logic [2:0]        scan_row       = '0;
    logic [1:0]        found_row      = '0;
    logic [1:0]        found_col      = '0;
    logic [NUM_W-1:0]  entry_value    = '0;
    logic [DEB_W-1:0]  debounce_ticks = DEB_RESET;

    logic [COL_W-1:0]  col_samples[$];
    t_result           expected_scans[$];

    logic              col_taken     = 1'b0;
    logic              quiet_run     = 1'b0;
    logic              long_hold_done = 1'b0;
    int                col_gap       = 0;
    int                hold_left     = 0;
    int                results_seen  = 0;
    int                mismatches    = 0;
    int                stall_cycles  = 0;

    keypad_scan_number_entry DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [CODE_W-1:0] char_of(input int idx);
        return KEY_CHARS[idx*8 +: 8];
    endfunction

    function automatic logic is_digit(input logic [CODE_W-1:0] ch);
        return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    endfunction

    // Advance the predicted scanner by one tick and return its result
    function automatic t_result scan_tick(input logic [COL_W-1:0] cols);
        t_result r;
        r = '0;
        case (scan_phase)
            PH_DEBOUNCE: begin
                if (deb_count != DEB_MAX)
                    deb_count = deb_count + 1'b1;
                if (deb_count >= debounce_ticks) begin
                    scan_row    = '0;
                    r.row_drive = ALL_HIGH & ~(4'b0001);
                    scan_phase  = PH_ROWSCAN;
                end
            end
            PH_ROWSCAN: begin
                if (cols != ALL_HIGH) begin
                    found_row  = scan_row[1:0];
                    scan_phase = PH_COLFIND;
                end else begin
                    scan_row = scan_row + 1'b1;
                    if (scan_row >= 3'd4)
                        scan_phase = PH_IDLE;
                    else
                        r.row_drive = ALL_HIGH & ~(4'b0001 << scan_row[1:0]);
                end
            end
            PH_COLFIND: begin
                // walk downwards so the lowest low column wins
                scan_phase = PH_IDLE;
                for (int c = 3; c >= 0; c--) begin
                    if (!cols[c]) begin
                        found_col  = c[1:0];
                        scan_phase = PH_RELEASE;
                    end
                end
            end
            PH_RELEASE: begin
                if (cols == ALL_HIGH) begin
                    r.key_valid = 1'b1;
                    r.key_code  = char_of({found_row, found_col});
                    scan_phase  = PH_IDLE;
                end
            end
            default: begin
                scan_phase = PH_IDLE;
                if (cols != ALL_HIGH) begin
                    deb_count  = '0;
                    scan_phase = PH_DEBOUNCE;
                end
            end
        endcase

        // Build the number on digits; close it on any other key
        r.number_value = entry_value;
        if (r.key_valid) begin
            if (is_digit(r.key_code)) begin
                entry_value    = entry_value * 10 + (r.key_code - CHAR_ZERO);
                r.number_value = entry_value;
            end else begin
                r.number_done = 1'b1;
                entry_value   = '0;
            end
        end
        return r;
    endfunction

    // Random column levels with column c low and every lower column high
    function automatic logic [COL_W-1:0] low_col_pattern(input int c);
        logic [COL_W-1:0] pat;
        pat    = 4'($urandom_range(0, 15));
        pat    = pat | ((4'b0001 << c) - 1'b1);
        pat[c] = 1'b0;
        return pat;
    endfunction

    // Queue one press; row 4 scans no row, col -1 finds no column
    task automatic queue_press(input int row, input int col, input int held);
        int d;
        d = (debounce_ticks == 0) ? 1 : int'(debounce_ticks);
        col_samples.push_back(4'($urandom_range(0, 14)));
        repeat (d) col_samples.push_back(4'($urandom_range(0, 15)));
        for (int j = 0; j < row && j < 4; j++)
            col_samples.push_back(ALL_HIGH);
        if (row < 4) begin
            col_samples.push_back(low_col_pattern(col < 0 ? $urandom_range(0, 3) : col));
            if (col < 0) begin
                col_samples.push_back(ALL_HIGH);
            end else begin
                col_samples.push_back(low_col_pattern(col));
                repeat (held) col_samples.push_back(4'($urandom_range(0, 14)));
                col_samples.push_back(ALL_HIGH);
            end
        end
    endtask

    // Queue mostly clean presses, some long digit runs, failed scans and noise
    task automatic queue_traffic(input int n);
        int start;
        int pick;
        int k;
        start = col_samples.size();
        while (col_samples.size() - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_press($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            end else if (pick < 80) begin
                // eight to thirteen digits; the longer runs wrap the number
                repeat ($urandom_range(8, 13)) begin
                    do k = $urandom_range(0, 15); while (!is_digit(char_of(k)));
                    queue_press(k / 4, k % 4, $urandom_range(0, 2));
                end
                queue_press($urandom_range(0, 3), $urandom_range(0, 3), 0);
            end else if (pick < 87) begin
                queue_press(4, 0, 0);
            end else if (pick < 93) begin
                queue_press($urandom_range(0, 3), -1, 0);
            end else begin
                // noise, then enough released ticks to drop back to idle
                repeat ($urandom_range(1, 6))
                    col_samples.push_back(4'($urandom_range(0, 15)));
                repeat (int'(debounce_ticks) + 6) col_samples.push_back(ALL_HIGH);
            end
        end
    endtask

    // Hold until every request is sent and every result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        while (col_samples.size() != 0 || s_axis_tvalid || expected_scans.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_debounce(input logic [DEB_W-1:0] ticks);
        wait_drained();
        i_cfg_wr_en    <= 1'b1;
        i_cfg_wr_data  <= ticks;
        debounce_ticks  = ticks;
        @(negedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Record each accepted request and predict its result
    always @(posedge i_clk) begin
        col_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_scans.push_back(scan_tick(s_axis_tdata[COL_W-1:0]));
    end

    // Offer the next column sample, with random gaps
    always @(negedge i_clk) begin : drive_cols
        logic             nv;
        logic [COL_W-1:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata[COL_W-1:0];
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_axis_tvalid || col_taken) begin
            nv = 1'b0;
            if (col_gap > 0) begin
                col_gap--;
            end else if (col_samples.size() != 0) begin
                if (!quiet_run && $urandom_range(0, 9) == 0) begin
                    col_gap = $urandom_range(0, 5);
                end else begin
                    nv = 1'b1;
                    nd = col_samples.pop_front();
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= {4'b0000, nd};
    end

    // Drive the result ready: short random stalls and one long hold-off
    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rdy            = 1'b0;
        end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 5);
            rdy       = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    // Check each result against the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (expected_scans.size() == 0) begin
                $display("%0t: result with none expected: tdata %h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_scans.pop_front();
                if (m_axis_tdata[3:0] !== want.row_drive) begin
                    $display("%0t: row_drive expected %h actual %h",
                             $time, want.row_drive, m_axis_tdata[3:0]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.key_valid) begin
                    $display("%0t: key_valid expected %b actual %b",
                             $time, want.key_valid, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[11:4] !== want.key_code) begin
                    $display("%0t: key_code expected %h actual %h",
                             $time, want.key_code, m_axis_tdata[11:4]);
                    mismatches++;
                end
                if (m_axis_tdata[43:12] !== want.number_value) begin
                    $display("%0t: number_value expected %0d actual %0d",
                             $time, want.number_value, m_axis_tdata[43:12]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.number_done) begin
                    $display("%0t: number_done expected %b actual %b",
                             $time, want.number_done, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Drop the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("keypad_scan_number_entry_test NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset debounce: clean keys, a finished number, failed scans
        queue_press(0, 0, 0);
        queue_press(0, 2, 2);
        queue_press(3, 3, 1);
        queue_press(4, 0, 0);
        queue_press(1, -1, 0);
        queue_press(1, 3, 0);

        // Zero debounce behaves as one tick
        write_debounce(16'd0);
        queue_press(2, 1, 0);
        queue_press(3, 1, 1);
        queue_press(3, 2, 0);
        queue_press(3, 0, 3);
        queue_press(0, 3, 0);
        queue_press(2, 3, 0);

        write_debounce(16'd1);
        queue_traffic(450);

        // Long debounce: a single press
        write_debounce(16'd40);
        queue_press($urandom_range(0, 3), $urandom_range(0, 3), 1);

        write_debounce(16'd3);
        queue_traffic(450);

        write_debounce(16'd2);
        queue_traffic(250);

        // Final stretch runs without gaps or stalls
        write_debounce(16'd1);
        quiet_run = 1'b1;
        queue_traffic(300);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (expected_scans.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_scans.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("keypad_scan_number_entry_test OK");
        else
            $display("keypad_scan_number_entry_test NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/kpsn_pkg.sv
hdl/kpsn_scan.sv
hdl/keypad_scan_number_entry.sv
test/keypad_scan_number_entry_test.sv
